/* rtl/xbf_pkg.sv */
// Package for the XMODEM-1K block framer: word types, queue command, constants,
// and the CRC-16/XMODEM byte update. Used by every RTL file of the block.
`default_nettype none
package xbf_pkg;

    localparam int BLOCK_BYTES = 1024;
    localparam int SLOT_W      = $clog2(BLOCK_BYTES);
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);

    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(BLOCK_BYTES - 1);
    localparam logic [7:0]        FRAME_STX   = 8'h02;
    localparam logic [7:0]        FILL_BYTE   = 8'hFF;
    localparam logic [15:0]       CRC_POLY    = 16'h1021;
    localparam logic [7:0]        PKT_NUM_RST = 8'd1;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_filler;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_done;
    } t_out_word;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic [7:0] pkt_num;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef enum logic [2:0] {
        PH_START,
        PH_NUM,
        PH_CPL,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO
    } t_phase;

    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/xmodem_block_framer.sv */
// XMODEM-1K packet framer with CRC-16/XMODEM; words pass a command queue and an output register.
// Throughput: one output word per cycle unless i_out_stall holds it or the queue is empty.
// A slot yields one word, a block's first slot four, its last three: BLOCK_BYTES+5 words per block.
// A 4-entry command queue lets input continue while the back end emits header or CRC words.
// Reset: synchronous, active low; packet number loads 1, slot and CRC clear, queue empties.
// Depends on xbf_pkg, xbf_front, xbf_queue, xbf_back.
`default_nettype none
module xmodem_block_framer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire xbf_pkg::t_in_word i_in_data,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output xbf_pkg::t_out_word     o_out_data,
    input  wire logic              i_out_stall,
    input  wire logic              i_cfg_valid,
    input  wire logic [7:0]        i_cfg_data,
    output logic                   o_cfg_ready
);

    logic             w_q_full;
    logic             w_push;
    xbf_pkg::t_cmd    w_push_cmd;
    logic             w_pop;
    xbf_pkg::t_q_head w_head;

    xbf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_push_cmd (w_push_cmd)
    );

    xbf_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_cmd(w_push_cmd),
        .o_full    (w_q_full),
        .i_pop     (w_pop),
        .o_head    (w_head)
    );

    xbf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

endmodule
`default_nettype wire

/* rtl/xbf_front.sv */
// Front end of the framer: accepts payload words, tracks slot and packet number,
// and turns each word into a queue command. Depends on xbf_pkg.
`default_nettype none
module xbf_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire xbf_pkg::t_in_word i_in_data,
    output logic                 o_in_stall,
    input  wire logic            i_cfg_valid,
    input  wire logic [7:0]      i_cfg_data,
    output logic                 o_cfg_ready,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output xbf_pkg::t_cmd        o_push_cmd
);

    logic [xbf_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [7:0]                 r_pkt, n_pkt;
    logic                       w_first, w_last;

    assign o_in_stall  = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign o_push      = i_in_valid && !i_q_full;

    assign w_first = (r_slot == '0);
    assign w_last  = (r_slot == xbf_pkg::LAST_SLOT);

    always_comb begin
        o_push_cmd.data    = i_in_data.is_filler ? xbf_pkg::FILL_BYTE : i_in_data.payload_byte;
        o_push_cmd.first   = w_first;
        o_push_cmd.last    = w_last;
        o_push_cmd.pkt_num = r_pkt;

        n_slot = r_slot;
        n_pkt  = r_pkt;
        if (o_push) begin
            n_slot = w_last ? '0 : r_slot + 1'b1;
            if (w_last) begin
                n_pkt = r_pkt + 8'd1;
            end
        end
        if (i_cfg_valid && o_cfg_ready) begin
            n_pkt = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_pkt  <= xbf_pkg::PKT_NUM_RST;
        end else begin
            r_slot <= n_slot;
            r_pkt  <= n_pkt;
        end
    end

endmodule
`default_nettype wire

/* rtl/xbf_queue.sv */
// Short command queue between front and back; the head is read combinationally.
// Depends on xbf_pkg.
`default_nettype none
module xbf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire xbf_pkg::t_cmd i_push_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output xbf_pkg::t_q_head   o_head
);

    xbf_pkg::t_cmd            r_mem [xbf_pkg::Q_DEPTH];
    logic [xbf_pkg::Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [xbf_pkg::Q_CW-1:0] r_count;

    assign o_full       = (r_count == xbf_pkg::Q_CW'(xbf_pkg::Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + xbf_pkg::Q_CW'(i_push) - xbf_pkg::Q_CW'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("queue pop while empty");
`endif

endmodule
`default_nettype wire

/* rtl/xbf_back.sv */
// Back end of the framer: walks the queued commands through header, data and
// CRC words, keeps the running CRC, and drives the output register. Uses xbf_pkg.
`default_nettype none
module xbf_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire xbf_pkg::t_q_head i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output xbf_pkg::t_out_word    o_out_data,
    input  wire logic             i_out_stall
);

    xbf_pkg::t_phase    r_state, n_state;
    logic [15:0]        r_crc, n_crc;
    logic               r_out_valid, n_out_valid;
    xbf_pkg::t_out_word r_out, n_out;
    logic               w_fire;
    logic [15:0]        w_crc_base;
    logic [15:0]        w_crc_upd;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_fire     = i_head.valid && (!r_out_valid || !i_out_stall);
    assign w_crc_base = i_head.cmd.first ? 16'h0000 : r_crc;
    assign w_crc_upd  = xbf_pkg::crc_add_byte(w_crc_base, i_head.cmd.data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xbf_pkg::PH_START;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_crc       = r_crc;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        if (w_fire) begin
            n_out_valid       = 1'b1;
            n_out.packet_done = 1'b0;
            case (r_state)
                xbf_pkg::PH_START: begin
                    if (i_head.cmd.first) begin
                        n_out.out_byte = xbf_pkg::FRAME_STX;
                        n_state        = xbf_pkg::PH_NUM;
                    end else begin
                        n_out.out_byte = i_head.cmd.data;
                        n_crc          = w_crc_upd;
                        if (i_head.cmd.last) begin
                            n_state = xbf_pkg::PH_CRC_HI;
                        end else begin
                            o_pop = 1'b1;
                        end
                    end
                end
                xbf_pkg::PH_NUM: begin
                    n_out.out_byte = i_head.cmd.pkt_num;
                    n_state        = xbf_pkg::PH_CPL;
                end
                xbf_pkg::PH_CPL: begin
                    n_out.out_byte = ~i_head.cmd.pkt_num;
                    n_state        = xbf_pkg::PH_DATA;
                end
                xbf_pkg::PH_DATA: begin
                    n_out.out_byte = i_head.cmd.data;
                    n_crc          = w_crc_upd;
                    if (i_head.cmd.last) begin
                        n_state = xbf_pkg::PH_CRC_HI;
                    end else begin
                        o_pop   = 1'b1;
                        n_state = xbf_pkg::PH_START;
                    end
                end
                xbf_pkg::PH_CRC_HI: begin
                    n_out.out_byte = r_crc[15:8];
                    n_state        = xbf_pkg::PH_CRC_LO;
                end
                xbf_pkg::PH_CRC_LO: begin
                    n_out.out_byte    = r_crc[7:0];
                    n_out.packet_done = 1'b1;
                    o_pop             = 1'b1;
                    n_state           = xbf_pkg::PH_START;
                end
                default: begin
                    n_out_valid = 1'b0;
                    n_state     = xbf_pkg::PH_START;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_crc_lo_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == xbf_pkg::PH_CRC_LO) |->
            ($past(r_state) == xbf_pkg::PH_CRC_HI || $past(r_state) == xbf_pkg::PH_CRC_LO))
        else $error("CRC low word not preceded by CRC high word");
    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != xbf_pkg::PH_START) |-> i_head.valid)
        else $error("command left the queue mid-sequence");
    a_done_only_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_state != xbf_pkg::PH_CRC_LO) |=> !r_out.packet_done)
        else $error("packet end flagged outside CRC low word");
`endif

endmodule
`default_nettype wire

/* tb/sv/xbf_frame_checker.sv */
`timescale 1ns / 1ps
// Checker for the XMODEM-1K block framer: tracks slot, CRC and packet number,
// predicts every framed word and compares it with the output channel. Needs xbf_pkg.
module xbf_frame_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire xbf_pkg::t_in_word  i_in_data,
    input  wire logic               i_in_stall,
    input  wire logic               i_out_valid,
    input  wire xbf_pkg::t_out_word i_out_data,
    input  wire logic               i_out_stall,
    input  wire logic               i_cfg_valid,
    input  wire logic [7:0]         i_cfg_data,
    input  wire logic               i_cfg_ready,
    output int                      o_mismatches,
    output int                      o_pending
);

    logic [xbf_pkg::SLOT_W-1:0] slot_idx = '0;
    logic [15:0]                crc_acc = '0;
    logic [7:0]                 pkt_num = xbf_pkg::PKT_NUM_RST;
    xbf_pkg::t_out_word         due_words[$];
    int                         bad_words = 0;

    function automatic logic [15:0] crc_shift_in(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r = {r[14:0], 1'b0} ^ (fb ? xbf_pkg::CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic push_due(input logic [7:0] v, input logic done);
        xbf_pkg::t_out_word e;
        e.out_byte = v;
        e.packet_done = done;
        due_words.push_back(e);
    endtask

    task automatic frame_slot(input xbf_pkg::t_in_word w);
        logic [7:0] b;
        b = w.is_filler ? xbf_pkg::FILL_BYTE : w.payload_byte;
        if (slot_idx == '0) begin
            crc_acc = '0;
            push_due(xbf_pkg::FRAME_STX, 1'b0);
            push_due(pkt_num, 1'b0);
            push_due(~pkt_num, 1'b0);
        end
        push_due(b, 1'b0);
        crc_acc = crc_shift_in(crc_acc, b);
        if (slot_idx == xbf_pkg::LAST_SLOT) begin
            push_due(crc_acc[15:8], 1'b0);
            push_due(crc_acc[7:0], 1'b1);
            pkt_num = pkt_num + 8'd1;
            slot_idx = '0;
            crc_acc = '0;
        end else begin
            slot_idx = slot_idx + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        xbf_pkg::t_out_word want;
        if (!i_rst_n) begin
            pkt_num = xbf_pkg::PKT_NUM_RST;
            slot_idx = '0;
            crc_acc = '0;
            due_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    bad_words++;
                    if (bad_words <= 10) begin
                        $display("%0t: unexpected word byte %02h done %0b", $realtime,
                                 i_out_data.out_byte, i_out_data.packet_done);
                    end
                end else begin
                    want = due_words.pop_front();
                    if (i_out_data.out_byte !== want.out_byte ||
                        i_out_data.packet_done !== want.packet_done) begin
                        bad_words++;
                        if (bad_words <= 10) begin
                            $display({"%0t: word mismatch: expected byte %02h done %0b, ",
                                      "got byte %02h done %0b"},
                                     $realtime, want.out_byte, want.packet_done,
                                     i_out_data.out_byte, i_out_data.packet_done);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                pkt_num = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                frame_slot(i_in_data);
            end
        end
        o_pending <= due_words.size();
        o_mismatches <= bad_words;
    end

endmodule

/* tb/sv/tb_xmodem_block_framer.sv */
`timescale 1ns / 1ps
// Top of the XMODEM-1K block framer testbench: clock, reset, bursty slot stimulus,
// receiver stalls, packet number writes and the verdict. Needs xbf_pkg and xbf_frame_checker.
module tb_xmodem_block_framer;

    localparam int IDLE_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    xbf_pkg::t_in_word  in_data = '0;
    logic               in_stall;
    logic               out_valid;
    xbf_pkg::t_out_word out_data;
    logic               out_stall = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [7:0]         cfg_data = 8'h00;
    logic               cfg_ready;

    int mismatches;
    int pending;
    int idle_cycles = 0;
    int stall_run = 0;
    bit stall_en = 1'b0;
    int max_gap = 0;
    int burst_left = 0;

    always #5 clk = ~clk;

    xmodem_block_framer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    xbf_frame_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_data    (in_data),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_data   (out_data),
        .i_out_stall  (out_stall),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_data   (cfg_data),
        .i_cfg_ready  (cfg_ready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // receiver stalls in runs of random length
    always @(posedge clk) begin
        if (stall_run == 0) begin
            stall_run <= $urandom_range(1, 12);
            out_stall <= stall_en && ($urandom_range(0, 2) == 0);
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_slot(input logic [7:0] b, input logic filler);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= {b, filler};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_slot(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic write_first_number(input logic [7:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_slot(8'h00, 1'b0);
        send_slot(8'hFF, 1'b0);
        send_slot(8'h00, 1'b1);
        send_slot(8'hA5, 1'b1);
        send_slot(8'h55, 1'b0);
        send_slot(8'hAA, 1'b0);
        send_slot(8'h01, 1'b0);
        send_slot(8'h80, 1'b0);
        send_slot(8'h7F, 1'b0);
        send_slot(8'hFE, 1'b0);
        send_slot(8'hFF, 1'b1);
        send_slot(8'h5A, 1'b0);

        // write lands mid-block
        write_first_number(8'h00);
        max_gap = 6;
        stall_en = 1'b1;
        send_random(110);

        write_first_number(8'hFF);
        max_gap = 3;
        send_random(100);

        write_first_number(8'($urandom_range(2, 254)));
        max_gap = 0;
        stall_en = 1'b0;
        send_random(50);

        max_gap = 10;
        stall_en = 1'b1;
        send_random(80);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/xbf_pkg.sv
rtl/xbf_front.sv
rtl/xbf_queue.sv
rtl/xbf_back.sv
rtl/xmodem_block_framer.sv
tb/sv/xbf_frame_checker.sv
tb/sv/tb_xmodem_block_framer.sv
